/* src/relay_packet_deframer_macros.svh */
// Assertion macros shared by the deframer RTL.
`ifndef RELAY_PACKET_DEFRAMER_MACROS_SVH
`define RELAY_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RPD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RPD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rpd_pkg.sv */
// Shared types and constants for the relay packet deframer.
package rpd_pkg;

    // Fixed field widths.
    localparam int CHANNEL_W = 4;
    localparam int BYTE_W    = 8;
    localparam int SENDER_W  = 4;
    localparam int FLEN_W    = 11;
    localparam int PCOUNT_W  = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Framing constants.
    localparam int SENDER_LIMIT  = 16;
    localparam int HEADER_BYTES  = 4;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_CHANNELS    = 16;
    localparam int DEF_MAX_FRAME_BYTES = 2048;

    // Result classification.
    typedef enum logic [2:0] {
        KIND_IGNORED,
        KIND_HEADER,
        KIND_PAYLOAD,
        KIND_BAD_SENDER,
        KIND_BAD_LENGTH
    } kind_t;

    // Parse position within a frame.
    typedef enum logic [2:0] {
        POS_SENDER,
        POS_DEST,
        POS_LEN_LO,
        POS_LEN_HI,
        POS_PAYLOAD
    } pos_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINK_ENABLED,
        CFG_HOST_MODE,
        CFG_PLAYER_COUNT
    } cfg_idx_t;

    // One result transaction.
    typedef struct packed {
        kind_t                kind;
        logic [SENDER_W-1:0]  sender;
        logic [BYTE_W-1:0]    destination;
        logic [FLEN_W-1:0]    frame_length;
        logic [BYTE_W-1:0]    payload_byte;
        logic                 deliver_local;
        logic                 relay_out;
        logic                 first_byte;
        logic                 last_byte;
    } res_t;

endpackage

/* src/rpd_if.sv */
// Valid/ready channel interfaces for received bytes and deframer results.
interface rpd_byte_if
    import rpd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel;
    logic [BYTE_W-1:0]    data_byte;

    modport source (output valid, output channel, output data_byte, input ready);
    modport sink   (input valid, input channel, input data_byte, output ready);
endinterface

interface rpd_result_if
    import rpd_pkg::*;
();
    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [SENDER_W-1:0] sender;
    logic [BYTE_W-1:0]   destination;
    logic [FLEN_W-1:0]   frame_length;
    logic [BYTE_W-1:0]   payload_byte;
    logic                deliver_local;
    logic                relay_out;
    logic                first_byte;
    logic                last_byte;

    modport source (
        output valid, output kind, output sender, output destination,
        output frame_length, output payload_byte, output deliver_local,
        output relay_out, output first_byte, output last_byte,
        input ready
    );
    modport sink (
        input valid, input kind, input sender, input destination,
        input frame_length, input payload_byte, input deliver_local,
        input relay_out, input first_byte, input last_byte,
        output ready
    );
endinterface

/* src/relay_packet_deframer.sv */
// A byte accepted into the context stage registers gives its result transaction from the output register.
// Throughput: one byte per cycle sustained while result.ready holds; bytes on the same channel may
// follow each other, since the context memory's registered read is bypassed by the write of the byte ahead.
// The pace is set by the single read-modify-write pass through the context memory.
// Reset returns configuration to its defaults and clears pipeline valids and per-channel valid bits; every parse
// context reads as zero at once, with no clearing pass.
`include "relay_packet_deframer_macros.svh"

module relay_packet_deframer
    import rpd_pkg::*;
#(
    parameter int MAX_CHANNELS    = DEF_MAX_CHANNELS,
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    rpd_byte_if.sink             rx,
    rpd_result_if.source         result
);

    localparam int AW  = $clog2(MAX_CHANNELS);
    localparam int CXW = CHANNEL_W + AW;
    localparam int LW  = $clog2(MAX_FRAME_BYTES);
    localparam int FXW = LW + FLEN_W;

    // Per-channel parse context as held in memory.
    typedef struct packed {
        pos_t              pos;
        logic [BYTE_W-1:0] snd;
        logic [BYTE_W-1:0] dst;
        logic [BYTE_W-1:0] len_lo;
        logic [LW-1:0]     rem;
        logic [LW-1:0]     tot;
    } ctx_t;

    localparam int CTX_W = $bits(ctx_t);

    logic                 link_en_reg;
    logic                 host_reg;
    logic [PCOUNT_W-1:0]  pcount_reg;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [CHANNEL_W-1:0] s1_ch_reg;
    logic [BYTE_W-1:0]    s1_byte_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    res_t                 res_reg;

    logic                 accept;
    logic                 s1_adv;
    logic [CXW-1:0]       rx_ch_ext;
    logic [CXW-1:0]       s1_ch_ext;
    logic [CTX_W-1:0]     ctx_rd;
    logic [CTX_W-1:0]     ctx_wr;
    ctx_t                 ctx;
    ctx_t                 ctx_next;
    res_t                 res_next;
    logic                 active;
    logic [2*BYTE_W-1:0]  len16;
    logic [FXW-1:0]       tot_ext;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_en_reg <= 1'b0;
            host_reg    <= 1'b0;
            pcount_reg  <= PCOUNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINK_ENABLED: link_en_reg <= cfg_data[0];
                CFG_HOST_MODE:    host_reg    <= cfg_data[0];
                CFG_PLAYER_COUNT: pcount_reg  <= cfg_data[PCOUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Handshake: a byte enters while the context stage is empty or moving on.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready = !s1_valid_reg || !out_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;

    assign s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the context stage and the output stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg   <= rx.channel;
            s1_byte_reg <= rx.data_byte;
        end
        if (s1_adv)
        begin
            res_reg <= res_next;
        end
    end

    // Channel numbers widened to index the context memory at any depth.
    assign rx_ch_ext = CXW'(rx.channel);
    assign s1_ch_ext = CXW'(s1_ch_reg);

    rpd_ctx_store #(
        .DEPTH (MAX_CHANNELS),
        .WIDTH (CTX_W)
    ) u_ctx_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rx_ch_ext[AW-1:0]),
        .rd_data (ctx_rd),
        .wr_en   (s1_adv && active),
        .wr_addr (s1_ch_ext[AW-1:0]),
        .wr_data (ctx_wr)
    );

    assign ctx     = ctx_t'(ctx_rd);
    assign ctx_wr  = ctx_next;
    assign len16   = {s1_byte_reg, ctx.len_lo};
    assign tot_ext = FXW'(ctx.tot);

    // Channel is live for the current mode.
    always_comb
    begin
        active = 1'b0;
        if (link_en_reg && (s1_ch_ext < CXW'(MAX_CHANNELS)))
        begin
            if (host_reg)
            begin
                active = (s1_ch_reg != '0) && (PCOUNT_W'(s1_ch_reg) < pcount_reg);
            end
            else
            begin
                active = (s1_ch_reg == '0);
            end
        end
    end

    // Parse step: classify the byte and update the channel context.
    always_comb
    begin
        ctx_next = ctx;
        res_next = '0;
        if (active)
        begin
            case (ctx.pos)
                POS_SENDER:
                begin
                    ctx_next.snd  = s1_byte_reg;
                    ctx_next.pos  = POS_DEST;
                    res_next.kind = KIND_HEADER;
                end
                POS_DEST:
                begin
                    ctx_next.dst         = s1_byte_reg;
                    ctx_next.pos         = POS_LEN_LO;
                    res_next.kind        = KIND_HEADER;
                    res_next.sender      = ctx.snd[SENDER_W-1:0];
                    res_next.destination = s1_byte_reg;
                end
                POS_LEN_LO:
                begin
                    ctx_next.len_lo      = s1_byte_reg;
                    ctx_next.pos         = POS_LEN_HI;
                    res_next.kind        = KIND_HEADER;
                    res_next.sender      = ctx.snd[SENDER_W-1:0];
                    res_next.destination = ctx.dst;
                end
                POS_LEN_HI:
                begin
                    res_next.destination = ctx.dst;
                    if (ctx.snd >= BYTE_W'(SENDER_LIMIT))
                    begin
                        res_next.kind = KIND_BAD_SENDER;
                        ctx_next.pos  = POS_SENDER;
                    end
                    else if ((len16 == '0) ||
                             (len16 > (2*BYTE_W)'(MAX_FRAME_BYTES - HEADER_BYTES)))
                    begin
                        res_next.kind   = KIND_BAD_LENGTH;
                        res_next.sender = ctx.snd[SENDER_W-1:0];
                        ctx_next.pos    = POS_SENDER;
                    end
                    else
                    begin
                        res_next.kind         = KIND_HEADER;
                        res_next.sender       = ctx.snd[SENDER_W-1:0];
                        res_next.frame_length = len16[FLEN_W-1:0];
                        ctx_next.tot          = LW'(len16);
                        ctx_next.rem          = LW'(len16);
                        ctx_next.pos          = POS_PAYLOAD;
                    end
                end
                default:
                begin
                    // Payload byte; unused position codes behave as payload too.
                    res_next.kind         = KIND_PAYLOAD;
                    res_next.sender       = ctx.snd[SENDER_W-1:0];
                    res_next.destination  = ctx.dst;
                    res_next.frame_length = tot_ext[FLEN_W-1:0];
                    res_next.payload_byte = s1_byte_reg;
                    if (host_reg)
                    begin
                        res_next.deliver_local = (ctx.dst == '0);
                        res_next.relay_out     = (ctx.dst != '0) &&
                                                 (ctx.dst < BYTE_W'(pcount_reg));
                    end
                    else
                    begin
                        res_next.deliver_local = 1'b1;
                    end
                    res_next.first_byte = (ctx.rem == ctx.tot);
                    res_next.last_byte  = (ctx.rem <= LW'(1));
                    if (ctx.rem <= LW'(1))
                    begin
                        ctx_next.rem = '0;
                        ctx_next.pos = POS_SENDER;
                    end
                    else
                    begin
                        ctx_next.rem = ctx.rem - LW'(1);
                    end
                end
            endcase
        end
    end

    // Result port.
    assign result.valid         = out_valid_reg;
    assign result.kind          = res_reg.kind;
    assign result.sender        = res_reg.sender;
    assign result.destination   = res_reg.destination;
    assign result.frame_length  = res_reg.frame_length;
    assign result.payload_byte  = res_reg.payload_byte;
    assign result.deliver_local = res_reg.deliver_local;
    assign result.relay_out     = res_reg.relay_out;
    assign result.first_byte    = res_reg.first_byte;
    assign result.last_byte     = res_reg.last_byte;

    // A stalled context stage sees no memory write, so its context must hold.
    `RPD_ASSERT_NEXT(a_ctx_hold, clk, rst_n, s1_valid_reg && !s1_adv, $stable(ctx_rd), "context changed while stage stalled")

    // Local delivery and relay are exclusive.
    `RPD_ASSERT_NOW(a_route_excl, clk, rst_n, out_valid_reg, !(res_reg.deliver_local && res_reg.relay_out), "byte both delivered and relayed")

    // Only payload results carry payload fields.
    `RPD_ASSERT_NOW(a_payload_only, clk, rst_n, out_valid_reg && (res_reg.kind != KIND_PAYLOAD), (res_reg.payload_byte == '0) && !res_reg.deliver_local && !res_reg.relay_out && !res_reg.first_byte && !res_reg.last_byte, "payload fields set on non-payload result")

    // An ignored byte yields an all-zero result.
    `RPD_ASSERT_NOW(a_ignored_zero, clk, rst_n, out_valid_reg && (res_reg.kind == KIND_IGNORED), (res_reg.sender == '0) && (res_reg.destination == '0) && (res_reg.frame_length == '0), "ignored byte carries frame fields")

endmodule

/* src/rpd_ctx_store.sv */
// Per-channel context memory: registered read, write-to-read forwarding, reset-valid bits.
module rpd_ctx_store #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] ctx_mem [DEPTH];
    logic [WIDTH-1:0] rd_q_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic [DEPTH-1:0] entry_valid_reg;
    logic             rd_valid_reg;
    logic             fwd_hit_reg;

    // Storage array and its registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ctx_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= ctx_mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Entry valid bits and the forwarding flag for a write to the entry being read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // A never-written entry reads as its reset value of zero.
    assign rd_data = fwd_hit_reg  ? fwd_data_reg :
                     rd_valid_reg ? rd_q_reg     : '0;

endmodule
